[rtl/assert_macros.svh]
// Assertion macros used by the core top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define C8_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define C8_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define C8_ASSERT(lbl, clk, rstn, prop, msg)
`define C8_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[rtl/c8_pkg.sv]
// Shared types and constants of the CHIP-8 subset core.
package c8_pkg;
  localparam int unsigned StackDepthDef = 16;
  localparam int unsigned MemBytesDef   = 4096;
  localparam int unsigned AddrW         = 12;
  localparam int unsigned PixW          = 11;
  localparam int unsigned ScreenPixels  = 2048;
  localparam logic [11:0] PcReset       = 12'h200;
  localparam logic [15:0] OpCls         = 16'h00E0;
  localparam logic [15:0] OpRet         = 16'h00EE;
  localparam logic [7:0]  KkWaitKey     = 8'h0A;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_EXEC = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } oper_e;

  typedef enum logic [3:0] {
    GRP_SYS  = 4'h0, GRP_JP = 4'h1, GRP_CALL = 4'h2, GRP_SE = 4'h3,
    GRP_LD   = 4'h6, GRP_ADD = 4'h7, GRP_LDI = 4'hA, GRP_RND = 4'hC,
    GRP_DRW  = 4'hD, GRP_F = 4'hF
  } grp_e;

  // display port request from the sequencer
  typedef struct packed {
    logic            we;
    logic [PixW-1:0] waddr;
    logic            wdata;
    logic [PixW-1:0] raddr;
  } fb_req_t;
endpackage

[rtl/c8_frame_mem.sv]
// 2048 x 1 display memory, registered read.
module c8_frame_mem (
  input  logic            clk_i,
  input  c8_pkg::fb_req_t req_i,
  output logic            rdata_o
);
  import c8_pkg::*;
  logic mem_q [ScreenPixels];
  always_ff @(posedge clk_i) begin
    if (req_i.we) mem_q[req_i.waddr] <= req_i.wdata;
    rdata_o <= mem_q[req_i.raddr];
  end
endmodule

[rtl/c8_prog_mem.sv]
// Program memory, one write and one registered read port.
module c8_prog_mem #(
  parameter int unsigned MemBytes = c8_pkg::MemBytesDef
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(MemBytes)-1:0] waddr_i,
  input  logic [7:0]               wdata_i,
  input  logic [$clog2(MemBytes)-1:0] raddr_i,
  output logic [7:0]               rdata_o
);
  logic [7:0] mem_q [MemBytes];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[rtl/chip8_core_subset_core.sv]
// Top level of the CHIP-8 subset core: sequencer, registers and memories.
// Usage:
//  - Input channel: in_valid_i/in_stall_o with operation, address, load data,
//    random byte and key code. One transaction is one operation.
//  - Output channel: out_valid_o/out_stall_i with next pc, fetched opcode,
//    pixel read value and VF. Exactly one result per input transaction.
//  - Sequence: a load goes on to S_DONE, a pixel read through S_PIXR, an
//    instruction through S_F0, S_F1 and S_DEC. A draw then reads each row
//    (up to 15 rows) and visits its 8 pixels in S_PRD, S_PWR (lit pixels
//    only) and S_PIXW; clear screen writes all 2048 pixels in S_CLR.
//  - One item at a time; the input stalls while an item is in flight or a
//    result waits in the output register.
//  - Reset: pc 0x200, V regs, index, stack and sp zero. The display memory
//    is cleared by a pass over all 2048 pixels after reset while the
//    input stalls. Program memory is undefined until loaded.
//  - When the receiver stalls, the result register holds its payload and
//    no new transaction is accepted.
module chip8_core_subset_core #(
  parameter int unsigned StackDepth = c8_pkg::StackDepthDef,
  parameter int unsigned MemBytes   = c8_pkg::MemBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [11:0] address_i,
  input  logic [7:0]  load_data_i,
  input  logic [7:0]  random_byte_i,
  input  logic [3:0]  key_code_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [11:0] next_pc_o,
  output logic [15:0] executed_opcode_o,
  output logic [7:0]  read_value_o,
  output logic [7:0]  flag_value_o
);
  import c8_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned MaW = $clog2(MemBytes);
  localparam int unsigned SpW = (StackDepth > 1) ? $clog2(StackDepth) : 1;

  typedef enum logic [11:0] {
    S_CLR   = 12'b000000000001,
    S_IDLE  = 12'b000000000010,
    S_F0    = 12'b000000000100,
    S_F1    = 12'b000000001000,
    S_DEC   = 12'b000000010000,
    S_RROW  = 12'b000000100000,
    S_WROW  = 12'b000001000000,
    S_PRD   = 12'b000010000000,
    S_PWR   = 12'b000100000000,
    S_PIXR  = 12'b001000000000,
    S_PIXW  = 12'b010000000000,
    S_DONE  = 12'b100000000000
  } state_e;

  state_e state_q, state_d;
  logic [7:0]  v_q [16];
  logic [11:0] idx_q, pc_q;
  logic [11:0] stk_q [StackDepth];
  logic [SpW-1:0] sp_q;
  logic [SpW-1:0] sp_dec;
  logic [1:0]  op_q;
  logic [11:0] addr_q;
  logic [7:0]  rnd_q;
  logic [3:0]  key_q;
  logic [15:0] ir_q;
  logic        hi_ok_q, lo_ok_q, row_ok_q;
  logic [11:0] cnt_q;          // clear counter / row number
  logic [2:0]  col_q;
  logic [7:0]  bits_q;
  logic [5:0]  x0_q;
  logic [4:0]  y0_q;
  logic        vf_set_q;
  logic        ovalid_q;
  logic [11:0] o_pc_q;
  logic [15:0] o_op_q;
  logic [7:0]  o_rv_q;
  logic [7:0]  o_vf_q;
  logic        in_acc;

  // memories
  logic        pm_we;
  logic [MaW-1:0] pm_ra;
  logic [7:0]  pm_rd;
  logic [11:0] pm_addr;
  fb_req_t     fb_req;
  logic        fb_rd;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE) || ovalid_q;
  assign pm_we = in_acc && (operation_i == OP_LOAD) && ({20'd0, address_i} < MemBytes);

  // stack pointer one below, wrapping at the configured depth
  assign sp_dec = (sp_q == '0) ? SpW'(StackDepth - 1) : sp_q - 1'b1;

  c8_prog_mem #(.MemBytes(MemBytes)) u_pm (
    .clk_i, .we_i(pm_we), .waddr_i(address_i[MaW-1:0]), .wdata_i(load_data_i),
    .raddr_i(pm_ra), .rdata_o(pm_rd)
  );
  c8_frame_mem u_fb (.clk_i, .req_i(fb_req), .rdata_o(fb_rd));

  // decoded fields
  logic [3:0] ix, iy, in_n;
  logic [7:0] kk;
  assign ix = ir_q[11:8];
  assign iy = ir_q[7:4];
  assign in_n = ir_q[3:0];
  assign kk = ir_q[7:0];

  logic [5:0] pcol;
  logic [4:0] prow;
  logic [PixW-1:0] ppix;
  assign pcol = x0_q + {3'd0, col_q};
  assign prow = y0_q + cnt_q[4:0];
  assign ppix = {prow, pcol};

  // program memory read address
  always_comb begin
    pm_addr = pc_q;
    case (state_q)
      S_F0:    pm_addr = pc_q + 12'd1;
      default: pm_addr = (state_q == S_DEC || state_q == S_WROW)
                         ? idx_q + cnt_q : pc_q;
    endcase
    pm_ra = pm_addr[MaW-1:0];
  end
  logic ra_ok;
  assign ra_ok = {20'd0, pm_addr} < MemBytes;

  always_comb begin
    fb_req.we    = 1'b0;
    fb_req.waddr = ppix;
    fb_req.wdata = ~fb_rd;
    fb_req.raddr = ppix;
    case (state_q)
      S_CLR: begin
        fb_req.we = 1'b1;
        fb_req.waddr = cnt_q[PixW-1:0];
        fb_req.wdata = 1'b0;
      end
      S_IDLE: fb_req.raddr = address_i[PixW-1:0];
      S_PWR:  fb_req.we = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      // the pass after reset returns no result
      S_CLR:  if (cnt_q == 12'(ScreenPixels - 1))
                state_d = (op_q == OP_EXEC) ? S_DONE : S_IDLE;
      S_IDLE: if (in_acc) begin
        case (oper_e'(operation_i))
          OP_EXEC: state_d = S_F0;
          OP_READ: state_d = S_PIXR;
          default: state_d = S_DONE;
        endcase
      end
      S_F0:   state_d = S_F1;
      S_F1:   state_d = S_DEC;
      S_DEC:  state_d = (ir_q[15:12] == GRP_DRW && in_n != 4'd0) ? S_RROW :
                        (ir_q == OpCls) ? S_CLR : S_DONE;
      S_RROW: state_d = S_PRD;
      S_PRD:  state_d = bits_q[7] ? S_PWR : S_PIXW;
      S_PWR:  state_d = S_PIXW;
      S_PIXW: state_d = (col_q != 3'd7) ? S_PRD :
                        (cnt_q[3:0] + 4'd1 == in_n) ? S_DONE : S_WROW;
      S_WROW: state_d = S_RROW;
      S_PIXR: state_d = S_DONE;
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      for (int i = 0; i < 16; i++) v_q[i] <= 8'd0;
      for (int i = 0; i < StackDepth; i++) stk_q[i] <= 12'd0;
      idx_q <= 12'd0;
      pc_q <= PcReset;
      sp_q <= '0;
      cnt_q <= 12'd0;
      ovalid_q <= 1'b0;
      op_q <= OP_NONE;
    end else begin
      state_q <= state_d;
      if (ovalid_q && !out_stall_i) ovalid_q <= 1'b0;
      case (state_q)
        S_CLR: cnt_q <= cnt_q + 12'd1;
        S_IDLE: if (in_acc) begin
          op_q <= operation_i; addr_q <= address_i;
          rnd_q <= random_byte_i; key_q <= key_code_i;
          cnt_q <= 12'd0; col_q <= 3'd0; vf_set_q <= 1'b0;
          hi_ok_q <= ra_ok;
        end
        // high byte read at pc was issued at the accepting edge
        S_F0: begin
          ir_q[15:8] <= hi_ok_q ? pm_rd : 8'd0;
          lo_ok_q <= ra_ok;
        end
        // low byte read at pc+1 was issued in S_F0
        S_F1: begin
          ir_q[7:0] <= lo_ok_q ? pm_rd : 8'd0;
          pc_q <= pc_q + 12'd2;
        end
        S_DEC: begin
          row_ok_q <= ra_ok;
          x0_q <= v_q[ix][5:0];
          y0_q <= v_q[iy][4:0];
          case (grp_e'(ir_q[15:12]))
            GRP_SYS: if (ir_q == OpRet) begin
              pc_q <= stk_q[sp_dec];
              sp_q <= sp_dec;
            end
            GRP_JP: pc_q <= ir_q[11:0];
            GRP_CALL: begin
              stk_q[sp_q] <= pc_q;
              sp_q <= (sp_q == SpW'(StackDepth - 1)) ? '0 : sp_q + 1'b1;
              pc_q <= ir_q[11:0];
            end
            GRP_SE: if (v_q[ix] == kk) pc_q <= pc_q + 12'd2;
            GRP_LD: v_q[ix] <= kk;
            GRP_ADD: v_q[ix] <= v_q[ix] + kk;
            GRP_LDI: idx_q <= ir_q[11:0];
            GRP_RND: v_q[ix] <= rnd_q & kk;
            GRP_DRW: v_q[15] <= 8'd0;
            GRP_F: if (kk == KkWaitKey) v_q[ix] <= {4'd0, key_q};
            default: ;
          endcase
          if (ir_q == OpCls) cnt_q <= 12'd0;
        end
        S_RROW: bits_q <= row_ok_q ? pm_rd : 8'd0;
        S_PWR: if (fb_rd) vf_set_q <= 1'b1;
        S_PIXW: begin
          bits_q <= {bits_q[6:0], 1'b0};
          col_q <= col_q + 3'd1;
          if (col_q == 3'd7) cnt_q <= cnt_q + 12'd1;
        end
        S_WROW: row_ok_q <= ra_ok;
        S_DONE: begin
          if (vf_set_q && op_q == OP_EXEC) v_q[15] <= 8'd1;
          ovalid_q <= 1'b1;
          o_pc_q <= pc_q;
          o_op_q <= (op_q == OP_EXEC) ? ir_q : 16'd0;
          o_rv_q <= (op_q == OP_READ) ? {7'd0, o_rv_q[0]} : 8'd0;
          o_vf_q <= (vf_set_q && op_q == OP_EXEC) ? 8'd1 : v_q[15];
          vf_set_q <= 1'b0;
        end
        default: ;
      endcase
      if (state_q == S_PIXR)
        o_rv_q <= {7'd0, fb_rd && (addr_q < 12'(ScreenPixels))};
    end
  end

  assign out_valid_o       = ovalid_q;
  assign next_pc_o         = o_pc_q;
  assign executed_opcode_o = o_op_q;
  assign read_value_o      = o_rv_q;
  assign flag_value_o      = o_vf_q;

  `C8_ASSERT(a_one_item, clk_i, rst_ni, ovalid_q |-> state_q == S_IDLE,
    "result pending while busy")
  `C8_ASSERT(a_stall_busy, clk_i, rst_ni, (state_q != S_IDLE) |-> in_stall_o,
    "input open while busy")
  `C8_ASSERT(a_done_valid, clk_i, rst_ni, (state_q == S_DONE) |=> out_valid_o,
    "no result after done")
endmodule
